// ===== design/lfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants of the link frame deframer
// Frame layout constants, status codes, register indexes, result types and
// the byte-wide CRC-16-CCITT update.
// ----------------------------------------------------------------------------
package lfd_pkg;

   localparam int unsigned HDR_BYTES = 15;
   localparam int unsigned CRC_BYTES = 2;

   localparam logic [7:0]  MAGIC_A       = 8'h44;
   localparam logic [7:0]  MAGIC_B       = 8'h34;
   localparam logic [7:0]  FRAME_VERSION = 8'h01;
   localparam logic [7:0]  TYPE_MAX      = 8'd9;
   localparam logic [7:0]  PROFILE_MAX   = 8'd2;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [8:0]  POS_MAX       = 9'd511;

   localparam logic [7:0]  PROFILE_NARROW = 8'd0;
   localparam logic [7:0]  PROFILE_MID    = 8'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_ALLOWED_FLAGS   = 2'd0;
   localparam logic [1:0] CSR_CAPACITY_NARROW = 2'd1;
   localparam logic [1:0] CSR_CAPACITY_MID    = 2'd2;
   localparam logic [1:0] CSR_CAPACITY_WIDE   = 2'd3;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_SHORT    = 4'd1,
      ST_MAGIC    = 4'd2,
      ST_VERSION  = 4'd3,
      ST_TYPE     = 4'd4,
      ST_PROFILE  = 4'd5,
      ST_LENGTH   = 4'd6,
      ST_CRC      = 4'd7,
      ST_FLAGS    = 4'd8,
      ST_CAPACITY = 4'd9
   } lfd_status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } lfd_kind_type;

   typedef struct packed {
      logic [7:0] allowed_flags;
      logic [7:0] capacity_narrow;
      logic [7:0] capacity_mid;
      logic [7:0] capacity_wide;
   } lfd_cfg_type;

   typedef struct packed {
      logic [7:0]  frame_type;
      logic [7:0]  link_profile;
      logic [7:0]  frame_flags;
      logic [15:0] session_id;
      logic [15:0] sequence_number;
      logic [15:0] ack_base;
      logic [15:0] ack_bitmap;
      logic [7:0]  payload_length;
   } lfd_hdr_type;

   typedef struct packed {
      lfd_kind_type   result_kind;
      logic [7:0]     payload_byte;
      logic [7:0]     payload_index;
      lfd_status_type status;
      lfd_hdr_type    hdr;
   } lfd_rsp_type;

   // MSB-first CRC-16-CCITT over one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== design/lfd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_if: valid/ready channels of the link frame deframer
// lfd_req_if carries received frame bytes, lfd_rsp_if carries results.
// ----------------------------------------------------------------------------
interface lfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;

   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface lfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [7:0]  payload_index;
   logic [3:0]  status;
   logic [7:0]  frame_type;
   logic [7:0]  link_profile;
   logic [7:0]  frame_flags;
   logic [15:0] session_id;
   logic [15:0] sequence_number;
   logic [15:0] ack_base;
   logic [15:0] ack_bitmap;
   logic [7:0]  payload_length;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output status, output frame_type,
                   output link_profile, output frame_flags, output session_id,
                   output sequence_number, output ack_base, output ack_bitmap,
                   output payload_length, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input status, input frame_type,
                   input link_profile, input frame_flags, input session_id,
                   input sequence_number, input ack_base, input ack_bitmap,
                   input payload_length, output ready);
endinterface

// ===== design/link_frame_deframer_crc16.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_frame_deframer_crc16: streaming CRC-16-CCITT frame deframer
// A byte's result shows on rsp after the byte is accepted; the byte sits in the
// input register, then its result lands in the result register.
// Throughput: one byte per cycle unless rsp stalls; the byte-wide CRC update and
// header checks sit between the input and result registers.
// Reset: synchronous, clears the frame state and loads the register defaults.
// ----------------------------------------------------------------------------
module link_frame_deframer_crc16 (
   input  logic       clock,
   input  logic       reset,
   lfd_req_if.sink    req,
   lfd_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   lfd_pkg::lfd_cfg_type cfg;
   lfd_pkg::lfd_rsp_type core_rsp;
   lfd_pkg::lfd_rsp_type out_ff;
   logic                 core_valid;
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_end_ff;
   logic                 out_valid_ff;
   logic                 advance;

   // move the held byte forward when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff <= req.rx_byte;
         in_end_ff  <= req.frame_end;
      end
   end

   lfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .rx_byte   (in_byte_ff),
      .frame_end (in_end_ff),
      .rsp_valid (core_valid),
      .rsp       (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= core_valid;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_valid) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.result_kind     = out_ff.result_kind;
   assign rsp.payload_byte    = out_ff.payload_byte;
   assign rsp.payload_index   = out_ff.payload_index;
   assign rsp.status          = out_ff.status;
   assign rsp.frame_type      = out_ff.hdr.frame_type;
   assign rsp.link_profile    = out_ff.hdr.link_profile;
   assign rsp.frame_flags     = out_ff.hdr.frame_flags;
   assign rsp.session_id      = out_ff.hdr.session_id;
   assign rsp.sequence_number = out_ff.hdr.sequence_number;
   assign rsp.ack_base        = out_ff.hdr.ack_base;
   assign rsp.ack_bitmap      = out_ff.hdr.ack_bitmap;
   assign rsp.payload_length  = out_ff.hdr.payload_length;

endmodule

// ===== design/lfd_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_csr: configuration registers
// Flag mask and per-profile payload capacities, written through a plain
// write port.
// ----------------------------------------------------------------------------
module lfd_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output lfd_pkg::lfd_cfg_type cfg
);

   lfd_pkg::lfd_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.allowed_flags   <= 8'd1;
         cfg_ff.capacity_narrow <= 8'd32;
         cfg_ff.capacity_mid    <= 8'd48;
         cfg_ff.capacity_wide   <= 8'd224;
      end else if (csr_we) begin
         unique case (csr_index)
            lfd_pkg::CSR_ALLOWED_FLAGS:   cfg_ff.allowed_flags   <= csr_wdata;
            lfd_pkg::CSR_CAPACITY_NARROW: cfg_ff.capacity_narrow <= csr_wdata;
            lfd_pkg::CSR_CAPACITY_MID:    cfg_ff.capacity_mid    <= csr_wdata;
            lfd_pkg::CSR_CAPACITY_WIDE:   cfg_ff.capacity_wide   <= csr_wdata;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/lfd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_core: per-frame state and result formation
// Tracks byte position, running CRC, first header error and header fields;
// forms a payload result for each payload byte and the status at frame end.
// ----------------------------------------------------------------------------
module lfd_core (
   input  logic                  clock,
   input  logic                  reset,
   input  lfd_pkg::lfd_cfg_type  cfg,
   input  logic                  advance,
   input  logic [7:0]            rx_byte,
   input  logic                  frame_end,
   output logic                  rsp_valid,
   output lfd_pkg::lfd_rsp_type  rsp
);

   localparam logic [8:0] PAY_START = 9'(lfd_pkg::HDR_BYTES);
   localparam logic [9:0] MIN_TOTAL = 10'(lfd_pkg::HDR_BYTES + lfd_pkg::CRC_BYTES);

   logic [8:0]              pos_ff, pos_in;
   logic [15:0]             crc_ff, crc_in;
   lfd_pkg::lfd_status_type err_ff, err_in, err_now;
   lfd_pkg::lfd_hdr_type    hdr_ff, hdr_in, hdr_cur;
   logic [9:0]              total;
   logic [9:0]              expected;
   logic [7:0]              cap;
   lfd_pkg::lfd_status_type status;

   always_comb begin
      hdr_cur = hdr_ff;
      err_now = lfd_pkg::ST_OK;
      unique case (pos_ff)
         9'd0:  if (rx_byte != lfd_pkg::MAGIC_A) err_now = lfd_pkg::ST_MAGIC;
         9'd1:  if (rx_byte != lfd_pkg::MAGIC_B) err_now = lfd_pkg::ST_MAGIC;
         9'd2:  if (rx_byte != lfd_pkg::FRAME_VERSION) err_now = lfd_pkg::ST_VERSION;
         9'd3: begin
            hdr_cur.frame_type = rx_byte;
            if (rx_byte > lfd_pkg::TYPE_MAX) err_now = lfd_pkg::ST_TYPE;
         end
         9'd4: begin
            hdr_cur.link_profile = rx_byte;
            if (rx_byte > lfd_pkg::PROFILE_MAX) err_now = lfd_pkg::ST_PROFILE;
         end
         9'd5:  hdr_cur.frame_flags            = rx_byte;
         9'd6:  hdr_cur.session_id[15:8]       = rx_byte;
         9'd7:  hdr_cur.session_id[7:0]        = rx_byte;
         9'd8:  hdr_cur.sequence_number[15:8]  = rx_byte;
         9'd9:  hdr_cur.sequence_number[7:0]   = rx_byte;
         9'd10: hdr_cur.ack_base[15:8]         = rx_byte;
         9'd11: hdr_cur.ack_base[7:0]          = rx_byte;
         9'd12: hdr_cur.ack_bitmap[15:8]       = rx_byte;
         9'd13: hdr_cur.ack_bitmap[7:0]        = rx_byte;
         9'd14: hdr_cur.payload_length         = rx_byte;
         default: ;
      endcase
   end

   assign crc_in   = lfd_pkg::crc16_byte(crc_ff, rx_byte);
   assign total    = {1'b0, pos_ff} + 10'd1;
   assign expected = MIN_TOTAL + {2'b00, hdr_cur.payload_length};

   always_comb begin
      if (hdr_cur.link_profile == lfd_pkg::PROFILE_NARROW) begin
         cap = cfg.capacity_narrow;
      end else if (hdr_cur.link_profile == lfd_pkg::PROFILE_MID) begin
         cap = cfg.capacity_mid;
      end else begin
         cap = cfg.capacity_wide;
      end
   end

   always_comb begin
      priority if (total < MIN_TOTAL) begin
         status = lfd_pkg::ST_SHORT;
      end else if (err_ff != lfd_pkg::ST_OK) begin
         status = err_ff;
      end else if (err_now != lfd_pkg::ST_OK) begin
         status = err_now;
      end else if (total != expected) begin
         status = lfd_pkg::ST_LENGTH;
      end else if (crc_in != 16'h0000) begin
         status = lfd_pkg::ST_CRC;
      end else if ((hdr_cur.frame_flags & ~cfg.allowed_flags) != 8'h00) begin
         status = lfd_pkg::ST_FLAGS;
      end else if (hdr_cur.payload_length > cap) begin
         status = lfd_pkg::ST_CAPACITY;
      end else begin
         status = lfd_pkg::ST_OK;
      end
   end

   always_comb begin
      rsp       = '0;
      rsp_valid = 1'b0;
      err_in    = (err_ff != lfd_pkg::ST_OK) ? err_ff : err_now;
      hdr_in    = hdr_cur;
      pos_in    = (pos_ff == lfd_pkg::POS_MAX) ? pos_ff : pos_ff + 9'd1;
      if (frame_end) begin
         rsp_valid       = 1'b1;
         rsp.result_kind = lfd_pkg::KIND_STATUS;
         rsp.status      = status;
         rsp.hdr         = hdr_cur;
         // start the next frame from a clean slate
         err_in = lfd_pkg::ST_OK;
         hdr_in = '0;
         pos_in = '0;
      end else if (pos_ff >= PAY_START &&
                   pos_ff < PAY_START + {1'b0, hdr_ff.payload_length}) begin
         rsp_valid         = 1'b1;
         rsp.result_kind   = lfd_pkg::KIND_PAYLOAD;
         rsp.payload_byte  = rx_byte;
         rsp.payload_index = 8'(pos_ff - PAY_START);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         crc_ff <= lfd_pkg::CRC_INIT;
         err_ff <= lfd_pkg::ST_OK;
         hdr_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
         crc_ff <= frame_end ? lfd_pkg::CRC_INIT : crc_in;
         err_ff <= err_in;
         hdr_ff <= hdr_in;
      end
   end

endmodule

// ===== design/lfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_checker: port-level assertions for the link frame deframer
// Checks result transaction framing and stall behavior on the rsp channel.
// ----------------------------------------------------------------------------
module lfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [7:0]  rsp_payload_index,
   input logic [3:0]  rsp_status,
   input logic [7:0]  rsp_frame_type,
   input logic [7:0]  rsp_link_profile,
   input logic [7:0]  rsp_frame_flags,
   input logic [15:0] rsp_session_id,
   input logic [15:0] rsp_sequence_number,
   input logic [15:0] rsp_ack_base,
   input logic [15:0] rsp_ack_bitmap,
   input logic [7:0]  rsp_payload_length
);

   // stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_payload_byte) && $stable(rsp_payload_index) &&
         $stable(rsp_status) && $stable(rsp_session_id))
      else $error("rsp transaction changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_payload_byte == 8'd0 &&
         rsp_payload_index == 8'd0)
      else $error("status transaction carries payload data");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_status == 4'd0 &&
         rsp_frame_type == 8'd0 && rsp_link_profile == 8'd0 &&
         rsp_frame_flags == 8'd0 && rsp_sequence_number == 16'd0 &&
         rsp_ack_base == 16'd0 && rsp_ack_bitmap == 16'd0 &&
         rsp_payload_length == 8'd0)
      else $error("payload transaction carries header fields");

endmodule

bind link_frame_deframer_crc16 lfd_checker u_lfd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_result_kind     (rsp.result_kind),
   .rsp_payload_byte    (rsp.payload_byte),
   .rsp_payload_index   (rsp.payload_index),
   .rsp_status          (rsp.status),
   .rsp_frame_type      (rsp.frame_type),
   .rsp_link_profile    (rsp.link_profile),
   .rsp_frame_flags     (rsp.frame_flags),
   .rsp_session_id      (rsp.session_id),
   .rsp_sequence_number (rsp.sequence_number),
   .rsp_ack_base        (rsp.ack_base),
   .rsp_ack_bitmap      (rsp.ack_bitmap),
   .rsp_payload_length  (rsp.payload_length)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for link_frame_deframer_crc16
// Streams framed bytes into the deframer while both channels idle at random,
// computes the payload and status transactions the frames must produce, and
// checks every result field against them. Directed frames cover good frames,
// each header error, short, overlong, length, CRC, flags and capacity cases,
// then randomized traffic runs under several register settings.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [7:0] PROFILE_WIDE  = 8'd2;
   localparam int         SETTLE_CYCLES = 4;
   localparam int         STUCK_LIMIT   = 2000;
   localparam int         RANDOM_BYTES  = 350;
   localparam int         MAX_PRINTED   = 40;

   // receiver stall modes
   localparam int RX_ALWAYS = 0;
   localparam int RX_HICCUP = 1;
   localparam int RX_COIN   = 2;
   localparam int RX_WINDOW = 3;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   lfd_req_if req_if ();
   lfd_rsp_if rsp_if ();

   link_frame_deframer_crc16 dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // deframer state mirrored on the bench side
   lfd_pkg::lfd_cfg_type    shadow_cfg;
   logic [8:0]              frame_pos;
   logic [15:0]             frame_crc;
   lfd_pkg::lfd_status_type frame_err;
   lfd_pkg::lfd_hdr_type    frame_hdr;
   lfd_pkg::lfd_rsp_type    deframed_q[$];

   logic [7:0] frame_buf[$];
   int         burst_left;
   int         rx_tick;
   int         rx_mode;
   int         stuck_cycles;
   int         bytes_sent;
   int         frames_sent;
   int         results_seen;
   int         mismatches;
   int         status_count[16];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc,
                                                  input logic [7:0]  data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ data[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ lfd_pkg::CRC_POLY;
         end
      end
      return c;
   endfunction

   task automatic clear_frame();
      frame_pos = '0;
      frame_crc = lfd_pkg::CRC_INIT;
      frame_err = lfd_pkg::ST_OK;
      frame_hdr = '0;
   endtask

   task automatic note_error(input lfd_pkg::lfd_status_type code);
      if (frame_err == lfd_pkg::ST_OK) begin
         frame_err = code;
      end
   endtask

   // advance the mirrored deframer by one accepted byte
   task automatic deframe_step(input logic [7:0] data, input logic is_last);
      int                      pos;
      int                      total;
      logic [7:0]              cap;
      lfd_pkg::lfd_status_type st;
      lfd_pkg::lfd_rsp_type    r;
      pos       = int'(frame_pos);
      frame_crc = crc_ccitt_next(frame_crc, data);
      case (pos)
         0: if (data != lfd_pkg::MAGIC_A) note_error(lfd_pkg::ST_MAGIC);
         1: if (data != lfd_pkg::MAGIC_B) note_error(lfd_pkg::ST_MAGIC);
         2: if (data != lfd_pkg::FRAME_VERSION) note_error(lfd_pkg::ST_VERSION);
         3: begin
            frame_hdr.frame_type = data;
            if (data > lfd_pkg::TYPE_MAX) note_error(lfd_pkg::ST_TYPE);
         end
         4: begin
            frame_hdr.link_profile = data;
            if (data > lfd_pkg::PROFILE_MAX) note_error(lfd_pkg::ST_PROFILE);
         end
         5:  frame_hdr.frame_flags            = data;
         6:  frame_hdr.session_id[15:8]       = data;
         7:  frame_hdr.session_id[7:0]        = data;
         8:  frame_hdr.sequence_number[15:8]  = data;
         9:  frame_hdr.sequence_number[7:0]   = data;
         10: frame_hdr.ack_base[15:8]         = data;
         11: frame_hdr.ack_base[7:0]          = data;
         12: frame_hdr.ack_bitmap[15:8]       = data;
         13: frame_hdr.ack_bitmap[7:0]        = data;
         14: frame_hdr.payload_length         = data;
         default: ;
      endcase
      r = '0;
      if (is_last) begin
         if (frame_hdr.link_profile == lfd_pkg::PROFILE_NARROW) begin
            cap = shadow_cfg.capacity_narrow;
         end else if (frame_hdr.link_profile == lfd_pkg::PROFILE_MID) begin
            cap = shadow_cfg.capacity_mid;
         end else begin
            cap = shadow_cfg.capacity_wide;
         end
         total = pos + 1;
         if (total < lfd_pkg::HDR_BYTES + lfd_pkg::CRC_BYTES) begin
            st = lfd_pkg::ST_SHORT;
         end else if (frame_err != lfd_pkg::ST_OK) begin
            st = frame_err;
         end else if (total != lfd_pkg::HDR_BYTES + lfd_pkg::CRC_BYTES +
                               frame_hdr.payload_length) begin
            st = lfd_pkg::ST_LENGTH;
         end else if (frame_crc != 16'h0000) begin
            st = lfd_pkg::ST_CRC;
         end else if ((frame_hdr.frame_flags & ~shadow_cfg.allowed_flags) != 8'h00) begin
            st = lfd_pkg::ST_FLAGS;
         end else if (frame_hdr.payload_length > cap) begin
            st = lfd_pkg::ST_CAPACITY;
         end else begin
            st = lfd_pkg::ST_OK;
         end
         r.result_kind = lfd_pkg::KIND_STATUS;
         r.status      = st;
         r.hdr         = frame_hdr;
         deframed_q = {deframed_q, r};
         status_count[st]++;
         clear_frame();
      end else begin
         if (frame_pos != lfd_pkg::POS_MAX) begin
            frame_pos = frame_pos + 9'd1;
         end
         if (pos >= lfd_pkg::HDR_BYTES &&
             pos < lfd_pkg::HDR_BYTES + frame_hdr.payload_length) begin
            r.result_kind   = lfd_pkg::KIND_PAYLOAD;
            r.payload_byte  = data;
            r.payload_index = 8'(pos - lfd_pkg::HDR_BYTES);
            deframed_q = {deframed_q, r};
         end
      end
   endtask

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("ERROR %0t: %s", $time, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                   results_seen, name, got, want));
      end
   endtask

   task automatic check_result();
      lfd_pkg::lfd_rsp_type want;
      if (deframed_q.size() == 0) begin
         report_mismatch("result transaction with nothing pending");
      end else begin
         want = deframed_q.pop_front();
         results_seen++;
         check_field("result_kind",     16'(rsp_if.result_kind),   16'(want.result_kind));
         check_field("payload_byte",    16'(rsp_if.payload_byte),  16'(want.payload_byte));
         check_field("payload_index",   16'(rsp_if.payload_index), 16'(want.payload_index));
         check_field("status",          16'(rsp_if.status),        16'(want.status));
         check_field("frame_type",      16'(rsp_if.frame_type),
                     16'(want.hdr.frame_type));
         check_field("link_profile",    16'(rsp_if.link_profile),
                     16'(want.hdr.link_profile));
         check_field("frame_flags",     16'(rsp_if.frame_flags),
                     16'(want.hdr.frame_flags));
         check_field("session_id",      rsp_if.session_id,      want.hdr.session_id);
         check_field("sequence_number", rsp_if.sequence_number,
                     want.hdr.sequence_number);
         check_field("ack_base",        rsp_if.ack_base,        want.hdr.ack_base);
         check_field("ack_bitmap",      rsp_if.ack_bitmap,      want.hdr.ack_bitmap);
         check_field("payload_length",  16'(rsp_if.payload_length),
                     16'(want.hdr.payload_length));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_result();
         end
         if (req_if.valid && req_if.ready) begin
            bytes_sent++;
            deframe_step(req_if.rx_byte, req_if.frame_end);
         end
      end
   end

   // end the run when no transaction of any kind moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results pending",
                  stuck_cycles, deframed_q.size());
         $display("** link_frame_deframer_crc16: FAILED **");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      rx_tick      = 0;
      rx_mode      = RX_ALWAYS;
      forever begin
         @(negedge clock);
         rx_tick++;
         if (rx_tick % 48 == 0) begin
            rx_mode = int'($urandom_range(RX_ALWAYS, RX_WINDOW));
         end
         case (rx_mode)
            RX_ALWAYS: rsp_if.ready <= 1'b1;
            RX_HICCUP: rsp_if.ready <= (rx_tick % 4) != 3;
            RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            default:   rsp_if.ready <= (rx_tick % 16) >= 10;
         endcase
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] data, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = int'($urandom_range(1, 24));
      end
      burst_left--;
      req_if.valid     <= 1'b1;
      req_if.rx_byte   <= data;
      req_if.frame_end <= is_last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (deframed_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write all four registers on back-to-back cycles; block must be idle
   task automatic set_config(input lfd_pkg::lfd_cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= lfd_pkg::CSR_ALLOWED_FLAGS;
      csr_wdata <= c.allowed_flags;
      @(negedge clock);
      csr_index <= lfd_pkg::CSR_CAPACITY_NARROW;
      csr_wdata <= c.capacity_narrow;
      @(negedge clock);
      csr_index <= lfd_pkg::CSR_CAPACITY_MID;
      csr_wdata <= c.capacity_mid;
      @(negedge clock);
      csr_index <= lfd_pkg::CSR_CAPACITY_WIDE;
      csr_wdata <= c.capacity_wide;
      @(negedge clock);
      csr_we     <= 1'b0;
      shadow_cfg  = c;
   endtask

   function automatic lfd_pkg::lfd_hdr_type rand_hdr(input logic [7:0] profile,
                                                     input logic [7:0] length,
                                                     input logic [7:0] flags);
      lfd_pkg::lfd_hdr_type h;
      h.frame_type      = 8'($urandom_range(0, lfd_pkg::TYPE_MAX));
      h.link_profile    = profile;
      h.frame_flags     = flags;
      h.session_id      = 16'($urandom);
      h.sequence_number = 16'($urandom);
      h.ack_base        = 16'($urandom);
      h.ack_bitmap      = 16'($urandom);
      h.payload_length  = length;
      return h;
   endfunction

   task automatic start_frame(input lfd_pkg::lfd_hdr_type h);
      frame_buf = {lfd_pkg::MAGIC_A, lfd_pkg::MAGIC_B, lfd_pkg::FRAME_VERSION,
                   h.frame_type, h.link_profile, h.frame_flags,
                   h.session_id[15:8], h.session_id[7:0],
                   h.sequence_number[15:8], h.sequence_number[7:0],
                   h.ack_base[15:8], h.ack_base[7:0],
                   h.ack_bitmap[15:8], h.ack_bitmap[7:0],
                   h.payload_length};
   endtask

   task automatic add_payload(input int count);
      repeat (count) frame_buf = {frame_buf, 8'($urandom)};
   endtask

   task automatic add_crc();
      logic [15:0] c;
      c = lfd_pkg::CRC_INIT;
      foreach (frame_buf[i]) c = crc_ccitt_next(c, frame_buf[i]);
      frame_buf = {frame_buf, c[15:8], c[7:0]};
   endtask

   task automatic truncate_frame(input int keep);
      while (frame_buf.size() > keep) frame_buf.pop_back();
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++) begin
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      end
      frames_sent++;
   endtask

   task automatic good_frame(input lfd_pkg::lfd_hdr_type h);
      start_frame(h);
      add_payload(int'(h.payload_length));
      add_crc();
      send_frame();
   endtask

   function automatic logic [7:0] pick_reg_value();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         2, 3:    return 8'($urandom_range(16, 64));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_good_frames();
      lfd_pkg::lfd_hdr_type h;
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd0, 8'h01));
      h = '{lfd_pkg::TYPE_MAX, PROFILE_WIDE, 8'h00, 16'hFFFF, 16'h0000, 16'hFFFF,
            16'h0000, 8'd3};
      good_frame(h);
      h = '{8'd0, lfd_pkg::PROFILE_MID, 8'h01, 16'h0000, 16'hFFFF, 16'h0000,
            16'hFFFF, 8'd0};
      good_frame(h);
      // one byte over the default narrow capacity
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd33, 8'h01));
   endtask

   task automatic test_header_errors();
      lfd_pkg::lfd_hdr_type h;
      h = rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd2, 8'h01);
      start_frame(h);
      frame_buf[0] = 8'h45;
      add_payload(2);
      add_crc();
      send_frame();
      start_frame(h);
      frame_buf[1] = 8'h00;
      add_payload(2);
      add_crc();
      send_frame();
      start_frame(h);
      frame_buf[2] = 8'hFF;
      add_payload(2);
      add_crc();
      send_frame();
      h.frame_type = lfd_pkg::TYPE_MAX + 8'd1;
      good_frame(h);
      h.frame_type = 8'hFF;
      good_frame(h);
      h.frame_type   = 8'd0;
      h.link_profile = lfd_pkg::PROFILE_MAX + 8'd1;
      good_frame(h);
      h.link_profile = 8'hFF;
      good_frame(h);
      // bad magic ahead of a bad type: magic wins
      h = rand_hdr(lfd_pkg::PROFILE_MID, 8'd0, 8'h01);
      h.frame_type = 8'hA0;
      start_frame(h);
      frame_buf[0] = 8'h00;
      add_crc();
      send_frame();
   endtask

   task automatic test_short_frames();
      lfd_pkg::lfd_hdr_type h;
      h = rand_hdr(PROFILE_WIDE, 8'd4, 8'h01);
      start_frame(h);
      truncate_frame(1);
      send_frame();
      start_frame(h);
      truncate_frame(5);
      send_frame();
      start_frame(h);
      add_payload(1);
      send_frame();
   endtask

   task automatic test_length_and_crc();
      lfd_pkg::lfd_hdr_type h;
      h = rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd4, 8'h01);
      start_frame(h);
      add_payload(5);
      add_crc();
      send_frame();
      start_frame(h);
      add_payload(3);
      add_crc();
      send_frame();
      // end inside the payload: only the status comes out for the last byte
      h = rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd10, 8'h01);
      start_frame(h);
      add_payload(6);
      send_frame();
      h = rand_hdr(lfd_pkg::PROFILE_MID, 8'd3, 8'h01);
      start_frame(h);
      add_payload(3);
      add_crc();
      frame_buf[frame_buf.size() - 1] ^= 8'h01;
      send_frame();
      h = rand_hdr(lfd_pkg::PROFILE_MID, 8'd2, 8'h01);
      start_frame(h);
      add_payload(3);
      add_crc();
      frame_buf[15] ^= 8'h80;
      send_frame();
      // overlong frame: position saturates, payload runs to index 254
      h = rand_hdr(PROFILE_WIDE, 8'd255, 8'h01);
      start_frame(h);
      add_payload(520 - int'(lfd_pkg::HDR_BYTES));
      send_frame();
   endtask

   task automatic test_flags_and_capacity();
      lfd_pkg::lfd_hdr_type h;
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd0, 8'h02));
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd40, 8'h80));
      // CRC is checked before flags
      start_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd2, 8'h02));
      add_payload(2);
      add_crc();
      frame_buf[15] ^= 8'h10;
      send_frame();
      wait_idle();
      set_config('{8'hFF, 8'd0, 8'd10, 8'd255});
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd0, 8'hFF));
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd1, 8'hFF));
      good_frame(rand_hdr(lfd_pkg::PROFILE_MID, 8'd10, 8'h5A));
      good_frame(rand_hdr(lfd_pkg::PROFILE_MID, 8'd11, 8'hA5));
      good_frame(rand_hdr(PROFILE_WIDE, 8'd40, 8'h00));
      wait_idle();
      set_config('{8'h00, 8'd255, 8'd0, 8'd0});
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd0, 8'h01));
      good_frame(rand_hdr(lfd_pkg::PROFILE_NARROW, 8'd12, 8'h00));
      h = rand_hdr(PROFILE_WIDE, 8'd1, 8'h00);
      good_frame(h);
   endtask

   task automatic test_random_traffic();
      lfd_pkg::lfd_cfg_type c;
      lfd_pkg::lfd_hdr_type h;
      int                   start_bytes;
      int                   pick;
      int                   len;
      logic [7:0]           prof;
      logic [7:0]           cap;
      logic [7:0]           flags;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         wait_idle();
         c.allowed_flags   = pick_reg_value();
         c.capacity_narrow = pick_reg_value();
         c.capacity_mid    = pick_reg_value();
         c.capacity_wide   = pick_reg_value();
         set_config(c);
         repeat ($urandom_range(6, 20)) begin
            if (bytes_sent - start_bytes >= RANDOM_BYTES) break;
            prof = 8'($urandom_range(0, lfd_pkg::PROFILE_MAX));
            cap  = (prof == lfd_pkg::PROFILE_NARROW) ? c.capacity_narrow :
                   (prof == lfd_pkg::PROFILE_MID) ? c.capacity_mid : c.capacity_wide;
            len  = ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 255)) :
                   int'($urandom_range(0, 24));
            if ($urandom_range(0, 3) != 0 && len > cap) begin
               len = int'($urandom_range(0, cap));
            end
            flags = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                    8'($urandom) & c.allowed_flags;
            h = rand_hdr(prof, 8'(len), flags);
            start_frame(h);
            pick = int'($urandom_range(0, 99));
            if (pick < 70) begin
               add_payload(len);
               add_crc();
            end else begin
               case (pick % 5)
                  0: begin
                     add_payload(len);
                     add_crc();
                     truncate_frame(int'($urandom_range(1, frame_buf.size() - 1)));
                  end
                  1: begin
                     frame_buf[$urandom_range(0, 4)] = 8'($urandom);
                     add_payload(len);
                     add_crc();
                  end
                  2: begin
                     add_payload(len);
                     add_crc();
                     frame_buf[$urandom_range(0, frame_buf.size() - 1)] ^=
                        8'(1 << $urandom_range(0, 7));
                  end
                  3: begin
                     add_payload((len > 0 && $urandom_range(0, 1) == 1) ? len - 1 : len + 1);
                     add_crc();
                  end
                  default: begin
                     // line noise
                     frame_buf.delete();
                     add_payload(int'($urandom_range(1, 40)));
                  end
               endcase
            end
            send_frame();
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.rx_byte   = 8'h00;
      req_if.frame_end = 1'b0;
      csr_we           = 1'b0;
      csr_index        = lfd_pkg::CSR_ALLOWED_FLAGS;
      csr_wdata        = 8'h00;
      burst_left       = 0;
      stuck_cycles     = 0;
      bytes_sent       = 0;
      frames_sent      = 0;
      results_seen     = 0;
      mismatches       = 0;
      foreach (status_count[i]) status_count[i] = 0;
      shadow_cfg = '{8'd1, 8'd32, 8'd48, 8'd224};
      clear_frame();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_good_frames();
      test_header_errors();
      test_short_frames();
      test_length_and_crc();
      test_flags_and_capacity();
      test_random_traffic();

      wait_idle();
      repeat (8) @(negedge clock);
      if (deframed_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", deframed_q.size()));
      end
      $display("Run covered %0d frames, %0d bytes, %0d results checked, %0d mismatches",
               frames_sent, bytes_sent, results_seen, mismatches);
      $display("Status mix: ok %0d short %0d magic %0d version %0d type %0d profile %0d %s",
               status_count[lfd_pkg::ST_OK], status_count[lfd_pkg::ST_SHORT],
               status_count[lfd_pkg::ST_MAGIC], status_count[lfd_pkg::ST_VERSION],
               status_count[lfd_pkg::ST_TYPE], status_count[lfd_pkg::ST_PROFILE],
               $sformatf("length %0d crc %0d flags %0d capacity %0d",
                         status_count[lfd_pkg::ST_LENGTH], status_count[lfd_pkg::ST_CRC],
                         status_count[lfd_pkg::ST_FLAGS],
                         status_count[lfd_pkg::ST_CAPACITY]));
      if (mismatches == 0) begin
         $display("** link_frame_deframer_crc16: PASSED **");
      end else begin
         $display("** link_frame_deframer_crc16: FAILED **");
      end
      $finish;
   end

endmodule
